// ----- rtl/core/three_axis_attitude_pid_macros.svh -----
// Assertion macros for the three-axis attitude PID block.
// Included by the RTL files that carry concurrent checks; needs aclk and aresetn in scope.
`ifndef THREE_AXIS_ATTITUDE_PID_MACROS_SVH
`define THREE_AXIS_ATTITUDE_PID_MACROS_SVH

// Same-cycle implication, checked out of reset
`define TAPID_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define TAPID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tapid_pkg.sv -----
// Shared types and constants for the three-axis attitude PID.
// No dependencies; used by tapid_mac and three_axis_attitude_pid.
package tapid_pkg;

    // Sizes of the stream words and fields
    localparam int AXES_DEF   = 3;
    localparam int THR_W      = 11;
    localparam int ANG_W      = 8;
    localparam int HEAD_W     = 9;
    localparam int DRV_W      = 16;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 64;

    // Configuration registers
    localparam int GAIN_W     = 48;
    localparam int GAIN_1_W   = 16;
    localparam int LIM_W      = 15;
    localparam int ALPHA_W    = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_ADDR_W-1:0] CFG_KP    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KI    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KD    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA = 3'd4;

    localparam logic [LIM_W-1:0]   LIM_RST   = 15'h7FFF;
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'hFFFF;

    // Datapath widths
    localparam int ERR_W   = 9;   // error, +-180
    localparam int SUM_W   = 16;  // clamped error sum
    localparam int SLOPE_W = 18;  // filtered slope, Q.8, +-92160
    localparam int MUL_A_W = 17;  // gain or alpha
    localparam int MUL_B_W = 19;  // error, sum, slope or slope gap
    localparam int ACC_W   = 41;  // Q.16 gain sum

    localparam int FRAC_SH = 8;
    localparam int Q_SH    = 16;

    // Heading wrap
    localparam logic signed [HEAD_W:0] YAW_HALF = 10'sd180;
    localparam logic signed [HEAD_W:0] YAW_FULL = 10'sd360;

    localparam int DRV_MAX = 32767;
    localparam int DRV_MIN = -32768;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_STOP = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALPHA,
        S_SLOPE,
        S_KP,
        S_KI,
        S_KD,
        S_DRIVE,
        S_EMIT
    } seq_state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD_SH,
        ACC_ADD_SH,
        ACC_ADD
    } acc_op_t;

endpackage

// ----- rtl/core/tapid_mac.sv -----
// Shared signed multiplier with registered product and accumulator.
// Depends on tapid_pkg for default widths and the accumulate op codes.
module tapid_mac #(
    parameter int A_W   = tapid_pkg::MUL_A_W,
    parameter int B_W   = tapid_pkg::MUL_B_W,
    parameter int ACC_W = tapid_pkg::ACC_W
) (
    input  logic                        aclk,
    input  logic signed [A_W-1:0]       op_a,
    input  logic signed [B_W-1:0]       op_b,
    input  tapid_pkg::acc_op_t          acc_op,
    output logic signed [A_W+B_W-1:0]   prod,
    output logic signed [ACC_W-1:0]     acc
);

    localparam int P_W = A_W + B_W;

    logic signed [P_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] prod_ext;

    assign prod_ext = ACC_W'(prod_reg);

    // load or accumulate the previous product, optionally scaled by 256, or hold
    always_comb begin
        case (acc_op)
            tapid_pkg::ACC_LOAD_SH: acc_next = prod_ext <<< tapid_pkg::FRAC_SH;
            tapid_pkg::ACC_ADD_SH:  acc_next = acc_reg + (prod_ext <<< tapid_pkg::FRAC_SH);
            tapid_pkg::ACC_ADD:     acc_next = acc_reg + prod_ext;
            default:                acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        acc_reg  <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

// ----- rtl/core/three_axis_attitude_pid.sv -----
// Three-axis attitude PID: one control tick in, one set of held drives out.
// Channels: s_* takes ticks (throttle, roll, pitch, heading); m_* returns throttle
// and the roll, pitch and yaw drives; cfg_* writes gains, integral limit and alpha.
// The first word after reset only primes the block and gives no result. Every
// later word gives exactly one result. s_tready is high only while the sequencer
// is idle. A word with non-zero throttle runs the PID over every axis through one
// shared multiplier: between accept and output, each axis goes through the alpha,
// slope, P, I, D and drive steps. A word with zero throttle updates only the run
// mode and goes straight to output. The result sits in an output register; the
// next word is accepted while it waits, and a stalled receiver holds the sequencer
// only when a new result is due. Configuration must be written by the user only
// while idle (the block does not check), one register per cycle, no read-back.
// Reset (aresetn low, synchronous) clears the run mode, the PID state, the held
// drives and the registers to their defaults (limit 32767, alpha 65535).
// Depends on tapid_pkg, tapid_mac and three_axis_attitude_pid_macros.svh.
`include "three_axis_attitude_pid_macros.svh"
module three_axis_attitude_pid #(
    parameter int AXES = tapid_pkg::AXES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // throttle[10:0], roll_angle[18:11], pitch_angle[26:19], heading[35:27]
    input  logic [tapid_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // throttle_cmd[10:0], roll_drive[26:11], pitch_drive[42:27], yaw_drive[58:43]
    output logic [tapid_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_we,
    input  logic [tapid_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tapid_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam logic [AW-1:0] AXIS_LAST = AW'(AXES - 1);
    localparam int P_W = tapid_pkg::MUL_A_W + tapid_pkg::MUL_B_W;
    localparam int Q_W = tapid_pkg::ACC_W - tapid_pkg::Q_SH;
    localparam int DRV_W = tapid_pkg::DRV_W;
    localparam int ERR_W = tapid_pkg::ERR_W;
    localparam int SUM_W = tapid_pkg::SUM_W;
    localparam int SLOPE_W = tapid_pkg::SLOPE_W;
    localparam int MB_W = tapid_pkg::MUL_B_W;
    localparam int MA_W = tapid_pkg::MUL_A_W;

    // input word fields
    logic [tapid_pkg::THR_W-1:0]         thr_in;
    logic signed [tapid_pkg::ANG_W-1:0]  roll_in;
    logic signed [tapid_pkg::ANG_W-1:0]  pitch_in;
    logic [tapid_pkg::HEAD_W-1:0]        head_in;

    assign thr_in   = s_tdata[10:0];
    assign roll_in  = signed'(s_tdata[18:11]);
    assign pitch_in = signed'(s_tdata[26:19]);
    assign head_in  = s_tdata[35:27];

    // configuration
    logic [tapid_pkg::GAIN_W-1:0]  kp_reg, ki_reg, kd_reg;
    logic [tapid_pkg::LIM_W-1:0]   lim_reg;
    logic [tapid_pkg::ALPHA_W-1:0] alpha_reg;

    // control and PID state
    tapid_pkg::seq_state_t state_reg, state_next;
    tapid_pkg::mode_t      mode_reg;
    logic                  primed_reg;
    logic [AW-1:0]         axis_reg, axis_next;
    logic [tapid_pkg::HEAD_W-1:0] yaw_ref_reg;

    logic [tapid_pkg::THR_W-1:0]        thr_reg;
    logic signed [tapid_pkg::ANG_W-1:0] roll_reg, pitch_reg;
    logic [tapid_pkg::HEAD_W-1:0]       head_reg;

    logic signed [SUM_W-1:0]   sum_reg   [AXES];
    logic signed [ERR_W-1:0]   prev_reg  [AXES];
    logic signed [SLOPE_W-1:0] slope_reg [AXES];
    logic signed [DRV_W-1:0]   drive_reg [AXES];

    logic                              m_valid_reg;
    logic [tapid_pkg::M_DATA_W-1:0]    m_data_reg;

    logic s_acc;
    logic out_load;

    assign s_tready = (state_reg == tapid_pkg::S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_load = (state_reg == tapid_pkg::S_EMIT) && (!m_valid_reg || m_tready);

    // yaw error relative to the latched reference, wrapped once to +-180
    logic signed [tapid_pkg::HEAD_W:0] yaw_diff, yaw_wrap;
    always_comb begin
        yaw_diff = signed'({1'b0, head_reg}) - signed'({1'b0, yaw_ref_reg});
        if (yaw_diff > tapid_pkg::YAW_HALF) begin
            yaw_wrap = yaw_diff - tapid_pkg::YAW_FULL;
        end else if (yaw_diff < -tapid_pkg::YAW_HALF) begin
            yaw_wrap = yaw_diff + tapid_pkg::YAW_FULL;
        end else begin
            yaw_wrap = yaw_diff;
        end
    end

    // error of the current axis
    logic [1:0]              axis_ext;
    logic signed [ERR_W-1:0] err;
    assign axis_ext = 2'(axis_reg);
    always_comb begin
        case (axis_ext)
            2'd0:    err = ERR_W'(roll_reg);
            2'd1:    err = ERR_W'(pitch_reg);
            default: err = ERR_W'(yaw_wrap);
        endcase
    end

    // clamped error sum
    logic signed [SUM_W:0]   sum_wide, lim_s;
    logic signed [SUM_W-1:0] sum_new;
    always_comb begin
        lim_s    = signed'({2'b00, lim_reg});
        sum_wide = (SUM_W+1)'(sum_reg[axis_reg]) + (SUM_W+1)'(err);
        if (sum_wide > lim_s) begin
            sum_new = SUM_W'(lim_s);
        end else if (sum_wide < -lim_s) begin
            sum_new = SUM_W'(-lim_s);
        end else begin
            sum_new = SUM_W'(sum_wide);
        end
    end

    // shared multiplier signals
    logic signed [MA_W-1:0] mac_a;
    logic signed [MB_W-1:0] mac_b;
    logic signed [P_W-1:0]  mac_prod;
    logic signed [tapid_pkg::ACC_W-1:0] mac_acc;
    tapid_pkg::acc_op_t     mac_op;

    // slope target and filter step
    logic signed [ERR_W:0]     delta;
    logic signed [SLOPE_W-1:0] target;
    logic signed [MB_W-1:0]    slope_gap;
    logic signed [P_W-17:0]    slope_step;
    logic signed [SLOPE_W-1:0] slope_new;
    always_comb begin
        delta      = (ERR_W+1)'(err) - (ERR_W+1)'(prev_reg[axis_reg]);
        target     = signed'({delta, 8'b0});
        slope_gap  = MB_W'(target) - MB_W'(slope_reg[axis_reg]);
        slope_step = signed'(mac_prod[P_W-1:16]);
        slope_new  = SLOPE_W'((P_W-16)'(slope_reg[axis_reg]) + slope_step);
    end

    // gains of the current axis
    logic [AW+3:0] gsel;
    logic signed [MA_W-1:0] kp_g, ki_g, kd_g;
    assign gsel = {axis_reg, 4'b0000};
    assign kp_g = MA_W'(signed'(kp_reg[gsel +: tapid_pkg::GAIN_1_W]));
    assign ki_g = MA_W'(signed'(ki_reg[gsel +: tapid_pkg::GAIN_1_W]));
    assign kd_g = MA_W'(signed'(kd_reg[gsel +: tapid_pkg::GAIN_1_W]));

    // shared multiplier
    tapid_mac #(
        .A_W   (MA_W),
        .B_W   (MB_W),
        .ACC_W (tapid_pkg::ACC_W)
    ) u_mac (
        .aclk   (aclk),
        .op_a   (mac_a),
        .op_b   (mac_b),
        .acc_op (mac_op),
        .prod   (mac_prod),
        .acc    (mac_acc)
    );

    // Q.16 sum to int16: truncate toward zero, then saturate
    logic signed [Q_W-1:0]   q_floor, q_trunc;
    logic                    round_up;
    logic signed [DRV_W-1:0] drive_new;
    always_comb begin
        q_floor  = signed'(mac_acc[tapid_pkg::ACC_W-1:tapid_pkg::Q_SH]);
        round_up = mac_acc[tapid_pkg::ACC_W-1] && (mac_acc[tapid_pkg::Q_SH-1:0] != '0);
        q_trunc  = q_floor + signed'(Q_W'(round_up));
        if (q_trunc > tapid_pkg::DRV_MAX) begin
            drive_new = DRV_W'(tapid_pkg::DRV_MAX);
        end else if (q_trunc < tapid_pkg::DRV_MIN) begin
            drive_new = DRV_W'(tapid_pkg::DRV_MIN);
        end else begin
            drive_new = DRV_W'(q_trunc);
        end
    end

    // sequencer: next state and multiplier operands
    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        mac_a      = '0;
        mac_b      = '0;
        mac_op     = tapid_pkg::ACC_HOLD;
        case (state_reg)
            tapid_pkg::S_IDLE: begin
                axis_next = '0;
                if (s_acc && primed_reg) begin
                    state_next = (thr_in != '0) ? tapid_pkg::S_ALPHA : tapid_pkg::S_EMIT;
                end
            end
            tapid_pkg::S_ALPHA: begin
                mac_a      = signed'({1'b0, alpha_reg});
                mac_b      = slope_gap;
                state_next = tapid_pkg::S_SLOPE;
            end
            tapid_pkg::S_SLOPE: begin
                mac_a      = kp_g;
                mac_b      = MB_W'(err);
                state_next = tapid_pkg::S_KP;
            end
            tapid_pkg::S_KP: begin
                mac_a      = ki_g;
                mac_b      = MB_W'(sum_reg[axis_reg]);
                mac_op     = tapid_pkg::ACC_LOAD_SH;
                state_next = tapid_pkg::S_KI;
            end
            tapid_pkg::S_KI: begin
                mac_a      = kd_g;
                mac_b      = MB_W'(slope_reg[axis_reg]);
                mac_op     = tapid_pkg::ACC_ADD_SH;
                state_next = tapid_pkg::S_KD;
            end
            tapid_pkg::S_KD: begin
                mac_op     = tapid_pkg::ACC_ADD;
                state_next = tapid_pkg::S_DRIVE;
            end
            tapid_pkg::S_DRIVE: begin
                if (axis_reg == AXIS_LAST) begin
                    state_next = tapid_pkg::S_EMIT;
                end else begin
                    axis_next  = axis_reg + AW'(1);
                    state_next = tapid_pkg::S_ALPHA;
                end
            end
            tapid_pkg::S_EMIT: begin
                if (out_load) begin
                    state_next = tapid_pkg::S_IDLE;
                end
            end
            default: state_next = tapid_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tapid_pkg::S_IDLE;
            axis_reg  <= '0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg    <= '0;
            ki_reg    <= '0;
            kd_reg    <= '0;
            lim_reg   <= tapid_pkg::LIM_RST;
            alpha_reg <= tapid_pkg::ALPHA_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                tapid_pkg::CFG_KP:    kp_reg    <= cfg_wdata;
                tapid_pkg::CFG_KI:    ki_reg    <= cfg_wdata;
                tapid_pkg::CFG_KD:    kd_reg    <= cfg_wdata;
                tapid_pkg::CFG_LIMIT: lim_reg   <= cfg_wdata[tapid_pkg::LIM_W-1:0];
                tapid_pkg::CFG_ALPHA: alpha_reg <= cfg_wdata[tapid_pkg::ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // captured tick, no reset needed
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            thr_reg   <= thr_in;
            roll_reg  <= roll_in;
            pitch_reg <= pitch_in;
            head_reg  <= head_in;
        end
    end

    // run mode, priming, reference and per-axis PID state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= tapid_pkg::MODE_IDLE;
            primed_reg  <= 1'b0;
            yaw_ref_reg <= '0;
            for (int i = 0; i < AXES; i++) begin
                sum_reg[i]   <= '0;
                prev_reg[i]  <= '0;
                slope_reg[i] <= '0;
                drive_reg[i] <= '0;
            end
        end else begin
            if (s_acc) begin
                if (!primed_reg) begin
                    primed_reg <= 1'b1;
                end else if (thr_in != '0) begin
                    if (mode_reg != tapid_pkg::MODE_RUN) begin
                        // start of a flight: fresh PID state, new yaw reference
                        mode_reg    <= tapid_pkg::MODE_RUN;
                        yaw_ref_reg <= head_in;
                        for (int i = 0; i < AXES; i++) begin
                            sum_reg[i]   <= '0;
                            prev_reg[i]  <= '0;
                            slope_reg[i] <= '0;
                        end
                    end
                end else if (mode_reg != tapid_pkg::MODE_IDLE) begin
                    mode_reg <= tapid_pkg::MODE_STOP;
                end
            end
            if (state_reg == tapid_pkg::S_ALPHA) begin
                sum_reg[axis_reg] <= sum_new;
            end
            if (state_reg == tapid_pkg::S_SLOPE) begin
                slope_reg[axis_reg] <= slope_new;
                prev_reg[axis_reg]  <= err;
            end
            if (state_reg == tapid_pkg::S_DRIVE) begin
                drive_reg[axis_reg] <= drive_new;
            end
        end
    end

    // result word; missing axes read as zero
    logic signed [DRV_W-1:0] drv_out [3];
    for (genvar k = 0; k < 3; k++) begin : g_drv
        if (k < AXES) begin : g_on
            assign drv_out[k] = drive_reg[k];
        end else begin : g_off
            assign drv_out[k] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {5'b0, drv_out[2], drv_out[1], drv_out[0], thr_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    `TAPID_ASSERT_NEXT(a_prime_only, s_acc && !primed_reg,
        primed_reg && state_reg == tapid_pkg::S_IDLE, "priming word left the idle state")
    `TAPID_ASSERT_NEXT(a_drive_hold, state_reg != tapid_pkg::S_DRIVE,
        $stable(drive_reg[0]), "held drive changed outside the drive step")
    `TAPID_ASSERT_NOW(a_emit_src, $rose(m_tvalid),
        $past(state_reg == tapid_pkg::S_EMIT), "result raised outside the emit step")
    `TAPID_ASSERT_NEXT(a_stop_mode,
        s_acc && primed_reg && thr_in == '0 && mode_reg != tapid_pkg::MODE_IDLE,
        mode_reg == tapid_pkg::MODE_STOP, "zero throttle did not stop the controller")

endmodule
